// ----- rtl/pnvm_pkg.sv -----
// ----------------------------------------------------------------------------
// pnvm_pkg
// Shared types and constants of the pink noise source.
// ----------------------------------------------------------------------------
package pnvm_pkg;

  // Width of one stored octave value, signed, units of 2^-24.
  localparam int unsigned DRAW_W   = 24;
  // Width of the octave sum and of the output sample.
  localparam int unsigned SUM_W    = 29;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned SEED_W   = 32;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;
  // Product of the sum and the zero-extended gain.
  localparam int unsigned PROD_W   = SUM_W + GAIN_W + 1;
  localparam int unsigned SCALE_SH = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SEED = 2'd2;

  // Input word kinds carried on tuser.
  localparam logic ACT_GENERATE = 1'b0;
  localparam logic ACT_RESTART  = 1'b1;

  // Reset values of the registers.
  localparam logic [COUNT_W-1:0] OCTAVE_COUNT_RST = 6'd16;
  localparam logic [GAIN_W-1:0]  GAIN_RST         = 16'd819;
  localparam logic [SEED_W-1:0]  SEED_RST         = 32'd42;

  // Control of the octave store.
  typedef struct packed {
    logic we;   // write the addressed entry
    logic clr;  // clear every entry
  } store_ctrl_t;

endpackage

// ----- rtl/pnvm_draw.sv -----
// ----------------------------------------------------------------------------
// pnvm_draw
// One xorshift32 step (13, 17, 5) and the centred 24-bit value it yields.
// ----------------------------------------------------------------------------
module pnvm_draw
  import pnvm_pkg::*;
(
  input  logic [SEED_W-1:0]        word_in,
  output logic [SEED_W-1:0]        word_out,
  output logic signed [DRAW_W-1:0] value
);

  logic [SEED_W-1:0] x1;
  logic [SEED_W-1:0] x2;

  assign x1       = word_in ^ (word_in << 13);
  assign x2       = x1 ^ (x1 >> 17);
  assign word_out = x2 ^ (x2 << 5);

  // Low 24 bits minus 2^23 is the same as inverting the top bit.
  assign value = signed'({~word_out[DRAW_W-1], word_out[DRAW_W-2:0]});

endmodule

// ----- rtl/pnvm_store.sv -----
// ----------------------------------------------------------------------------
// pnvm_store
// Octave value store: one address shared by writes and reads, cleared as a whole.
// ----------------------------------------------------------------------------
module pnvm_store
  import pnvm_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  store_ctrl_t              ctrl,
  input  logic [AW-1:0]            addr,
  input  logic signed [DRAW_W-1:0] wdata,
  output logic signed [DRAW_W-1:0] rdata
);

  logic signed [DRAW_W-1:0] entry [DEPTH];

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry[i] <= '0;
      end
    end else if (ctrl.we) begin
      entry[addr] <= wdata;
    end
  end

  assign rdata = entry[addr];

endmodule

// ----- rtl/pink_noise_voss_mccartney.sv -----
// ----------------------------------------------------------------------------
// pink_noise_voss_mccartney
// Voss-McCartney pink noise source with a shared xorshift32 draw unit.
// ----------------------------------------------------------------------------
// A generate word (tuser low) produces one signed 29-bit sample in units of
// 2^-24; a restart word (tuser high) reseeds the generator from tdata, or
// from default_seed when tdata is zero, clears every octave value and zeroes
// the sample count, and produces no sample. Once a generate word is
// accepted, the sequencer visits one octave per cycle for octave_count
// octaves (clamped to MAX_OCTAVES) through the single xorshift unit and
// the single-port octave store, then passes the sum through the gain
// multiplier and loads the output register. A restart leaves the block
// idle. The input is not ready while a sample is being
// worked out. A finished sample waits in the output register; while it is
// unread, the next sample holds in the multiplier stage, and the next word
// is taken at the earliest in the cycle after that sample has been loaded.
// Configuration may only be written while the block is idle.
// ----------------------------------------------------------------------------
module pink_noise_voss_mccartney
  import pnvm_pkg::*;
#(
  parameter int unsigned MAX_OCTAVES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]    cfg_data,
  // Input words.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [31:0] restart seed
  input  logic                 s_tuser,   // [0] action
  // Output words.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata    // [28:0] sample, [31:29] zero
);

  localparam int unsigned AW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Configuration registers.
  logic [COUNT_W-1:0] octave_count;
  logic [GAIN_W-1:0]  gain;
  logic [SEED_W-1:0]  default_seed;

  // Generator state and sequencer.
  logic [1:0]              state;
  logic [SEED_W-1:0]       rng_word;
  logic [31:0]             sample_index;
  logic [AW-1:0]           octave;
  logic [AW-1:0]           last_octave;
  logic                    zero_run;
  logic signed [SUM_W-1:0] sum;
  logic signed [PROD_W-1:0] product;
  logic [SUM_W-1:0]        sample;
  logic                    out_valid;

  logic [COUNT_W-1:0]       eff_count;
  logic [COUNT_W-1:0]       eff_minus_one;
  logic [SEED_W-1:0]        draw_word;
  logic signed [DRAW_W-1:0] draw_value;
  logic signed [DRAW_W-1:0] stored_value;
  logic signed [DRAW_W-1:0] octave_value;
  store_ctrl_t              store_ctrl;
  logic                     accept;
  logic                     load_out;

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(32 - SUM_W){1'b0}}, sample};

  // The output register takes a new sample once it is empty or being read.
  assign load_out = (state == ST_FIN) && (!out_valid || m_tready);

  // Counts above the store depth behave as the full depth.
  assign eff_count     = (octave_count > COUNT_W'(MAX_OCTAVES)) ?
                         COUNT_W'(MAX_OCTAVES) : octave_count;
  assign eff_minus_one = eff_count - COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OCTAVE_COUNT_RST;
      gain         <= GAIN_RST;
      default_seed <= SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OCTAVE_COUNT: octave_count <= cfg_data[COUNT_W-1:0];
        REG_GAIN:         gain         <= cfg_data[GAIN_W-1:0];
        REG_DEFAULT_SEED: default_seed <= cfg_data;
        default: ;
      endcase
    end
  end

  pnvm_draw u_draw (
    .word_in  (rng_word),
    .word_out (draw_word),
    .value    (draw_value)
  );

  // An octave draws afresh while the low bits of the sample count seen so
  // far are all zero; octave 0 always draws.
  assign octave_value = zero_run ? draw_value : stored_value;

  always_comb begin
    store_ctrl.we  = (state == ST_ACC) && zero_run;
    store_ctrl.clr = accept && (s_tuser == ACT_RESTART);
  end

  pnvm_store #(
    .DEPTH (MAX_OCTAVES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (store_ctrl),
    .addr  (octave),
    .wdata (draw_value),
    .rdata (stored_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rng_word     <= SEED_RST;
      sample_index <= '0;
      out_valid    <= 1'b0;
      octave       <= '0;
      last_octave  <= '0;
      zero_run     <= 1'b0;
      sum          <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == ACT_RESTART) begin
              rng_word     <= (s_tdata != '0) ? s_tdata : default_seed;
              sample_index <= '0;
            end else begin
              octave      <= '0;
              last_octave <= eff_minus_one[AW-1:0];
              zero_run    <= 1'b1;
              sum         <= '0;
              state       <= (eff_count == '0) ? ST_MUL : ST_ACC;
            end
          end
        end
        ST_ACC: begin
          if (zero_run) begin
            rng_word <= draw_word;
          end
          sum      <= sum + SUM_W'(octave_value);
          zero_run <= zero_run && !sample_index[octave];
          octave   <= octave + AW'(1);
          if (octave == last_octave) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          sample_index <= sample_index + 32'd1;
          state        <= ST_FIN;
        end
        ST_FIN: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Gain stage: the arithmetic shift right by 16 rounds toward minus
  // infinity, and the sample keeps the low 29 bits of the shifted product.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      product <= PROD_W'(sum) * PROD_W'(signed'({1'b0, gain}));
    end
    if (load_out) begin
      sample <= product[SCALE_SH + SUM_W - 1:SCALE_SH];
    end
  end

endmodule

// ----- sim/pink_noise_voss_mccartney_test.sv -----
// ----------------------------------------------------------------------------
// pink_noise_voss_mccartney_test
// Self-checking regression for the Voss-McCartney pink noise source.
// ----------------------------------------------------------------------------
// A behavioural model of the octave rows, the xorshift32 generator and the
// gain stage runs beside the block. Every input word that the block accepts
// is also applied to the model, and every sample the model produces is
// queued. Each output word is then checked against the oldest queued sample.
// A directed part covers the register extremes, both word kinds and the
// corner cases of the algorithm. A long random part then follows, with both
// sides of the stream idling at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pink_noise_voss_mccartney_test;
  import pnvm_pkg::*;

  localparam int OCTAVE_ROWS = 32;
  // This pause is enough for a word still in flight to finish before a
  // register write.
  localparam int DRAIN_CYCLES = OCTAVE_ROWS + 8;
  // Cycles without any accepted word before the run is abandoned. The worst
  // correct stall is a sender gap, a full generate and a receiver stall, or
  // a drain pause followed by a few register writes.
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_WORDS = 1450;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SEED_W-1:0]    cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;
  logic                 s_tuser = ACT_GENERATE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;

  pink_noise_voss_mccartney #(
    .MAX_OCTAVES(OCTAVE_ROWS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] restart seed
    .s_tuser  (s_tuser),   // [0] action
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [28:0] sample, [31:29] zero
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // --------------------------------------------------------------------------
  // Noise model: register copies and generator state.
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0]       octaves_reg = OCTAVE_COUNT_RST;
  logic [GAIN_W-1:0]        gain_reg    = GAIN_RST;
  logic [SEED_W-1:0]        seed_reg    = SEED_RST;
  logic [31:0]              lfsr_word   = SEED_RST;
  logic signed [DRAW_W-1:0] octave_rows [OCTAVE_ROWS];
  logic [31:0]              sample_count = '0;

  // Samples worked out by the model and not yet seen on the output.
  logic [31:0] pending_samples [$];
  int          failures = 0;

  // Idle modes of the two sides; when clear that side never pauses.
  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;

  initial begin
    for (int k = 0; k < OCTAVE_ROWS; k++) octave_rows[k] = '0;
  end

  // Applies one accepted input word to the model. A generate word pushes
  // the sample that the block has to produce for it.
  task automatic advance_noise_model(input logic act, input logic [31:0] seed);
    int          rows;
    longint      row_sum;
    longint      scaled;
    logic [31:0] x;
    logic [31:0] mask;
    if (act == ACT_RESTART) begin
      lfsr_word = (seed != 32'd0) ? seed : seed_reg;
      for (int k = 0; k < OCTAVE_ROWS; k++) octave_rows[k] = '0;
      sample_count = '0;
    end else begin
      rows = (octaves_reg > OCTAVE_ROWS) ? OCTAVE_ROWS : int'(octaves_reg);
      row_sum = 0;
      for (int k = 0; k < rows; k++) begin
        mask = (32'd1 << k) - 32'd1;
        // Row k is refreshed whenever the low k bits of the count are zero.
        if ((sample_count & mask) == 32'd0) begin
          x = lfsr_word;
          x = x ^ (x << 13);
          x = x ^ (x >> 17);
          x = x ^ (x << 5);
          lfsr_word = x;
          // Low 24 bits minus 2^23 is the same as flipping bit 23.
          octave_rows[k] = {~x[23], x[22:0]};
        end
        row_sum += longint'(octave_rows[k]);
      end
      // Arithmetic shift of a signed product rounds towards minus infinity.
      scaled = (row_sum * longint'(gain_reg)) >>> SCALE_SH;
      pending_samples.push_back({3'b000, scaled[SUM_W-1:0]});
      sample_count += 32'd1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Offers one input word after a random gap and returns just after the
  // rising edge at which it was taken. The valid line is only lowered when
  // a gap is due, so back-to-back words keep it high.
  task automatic send_word(input logic act, input logic [31:0] seed);
    int gap;
    gap = src_idle ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = seed;
    do @(posedge clk); while (s_tready !== 1'b1);
    advance_noise_model(act, seed);
  endtask

  task automatic generate_words(input int count);
    repeat (count) send_word(ACT_GENERATE, $urandom);
  endtask

  // Waits until every queued sample has been seen, then lets any restart
  // still in the block finish, so that the registers may be written.
  task automatic drain_and_pause();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEED_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_OCTAVE_COUNT: octaves_reg = val[COUNT_W-1:0];
      REG_GAIN:         gain_reg    = val[GAIN_W-1:0];
      REG_DEFAULT_SEED: seed_reg    = val;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Output checker: drives tready with random stalls and compares every
  // output word with the oldest queued sample.
  // --------------------------------------------------------------------------
  initial begin : sample_checker
    int          gap;
    logic [31:0] want;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if (pending_samples.size() == 0) begin
        failures++;
        $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
      end else begin
        want = pending_samples.pop_front();
        if (m_tdata !== want) begin
          failures++;
          $display("%0t: sample mismatch, expected %0d (%h), actual %0d (%h)", $time,
                   $signed(want[SUM_W-1:0]), want, $signed(m_tdata[SUM_W-1:0]), m_tdata);
        end
      end
      // Now and then switch between stalling and always-ready stretches.
      if ($urandom_range(0, 63) == 0) sink_idle = !sink_idle;
      @(negedge clk);
    end
  end

  // The run is abandoned if no word moves on either side for too long.
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall = 0;
      else stall++;
    end
    $display("pink_noise_voss_mccartney regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test tasks.
  // --------------------------------------------------------------------------

  // The first samples after reset use the reset registers and seed 42.
  task automatic test_reset_state();
    generate_words(3);
  endtask

  // Restart with an all-ones seed, then with a zero seed, which falls back
  // on the default seed register.
  task automatic test_restart_seeds();
    send_word(ACT_RESTART, 32'hFFFF_FFFF);
    generate_words(2);
    send_word(ACT_RESTART, 32'd0);
    generate_words(1);
  endtask

  // Octave count and gain at their extremes, including a count above the
  // row limit, which acts as the limit, and a count of zero, which gives a
  // zero sample and leaves the generator where it is.
  task automatic test_register_extremes();
    drain_and_pause();
    write_reg(REG_OCTAVE_COUNT, 1);
    write_reg(REG_GAIN, 32'h0000_FFFF);
    generate_words(2);
    drain_and_pause();
    write_reg(REG_OCTAVE_COUNT, OCTAVE_ROWS);
    generate_words(2);
    drain_and_pause();
    write_reg(REG_OCTAVE_COUNT, 63);
    generate_words(1);
    drain_and_pause();
    write_reg(REG_OCTAVE_COUNT, 0);
    generate_words(1);
    drain_and_pause();
    write_reg(REG_OCTAVE_COUNT, OCTAVE_ROWS);
    write_reg(REG_GAIN, 0);
    generate_words(1);
  endtask

  // A zero default seed locks the generator at zero, so every draw is the
  // most negative value. A later write of the seed register must not touch
  // the running generator, only the next restart.
  task automatic test_zero_seed();
    drain_and_pause();
    write_reg(REG_GAIN, 32'h0000_FFFF);
    write_reg(REG_DEFAULT_SEED, 32'd0);
    send_word(ACT_RESTART, 32'd0);
    generate_words(2);
    drain_and_pause();
    write_reg(REG_DEFAULT_SEED, 32'h8000_0001);
    generate_words(1);
    send_word(ACT_RESTART, 32'd0);
    generate_words(1);
  endtask

  // Rows left out by a lowered count keep their old values, and these are
  // summed again once the count is raised.
  task automatic test_raised_count();
    drain_and_pause();
    write_reg(REG_OCTAVE_COUNT, 20);
    generate_words(1);
    drain_and_pause();
    write_reg(REG_OCTAVE_COUNT, 4);
    generate_words(3);
    drain_and_pause();
    write_reg(REG_OCTAVE_COUNT, 20);
    generate_words(1);
  endtask

  // Random phases: each one writes every register, then sends a burst of
  // mostly generate words with the odd restart in between.
  task automatic test_random_traffic();
    int sent;
    int burst;
    int pick;
    logic [SEED_W-1:0] val;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      drain_and_pause();
      pick = $urandom_range(0, 9);
      case (pick)
        0:       val = 0;
        1:       val = $urandom_range(OCTAVE_ROWS + 1, 63);
        2:       val = OCTAVE_ROWS;
        3:       val = 1;
        default: val = $urandom_range(1, OCTAVE_ROWS - 1);
      endcase
      write_reg(REG_OCTAVE_COUNT, val);
      pick = $urandom_range(0, 9);
      val = (pick == 0) ? 0 : (pick == 1) ? 32'h0000_FFFF : {16'd0, 16'($urandom)};
      write_reg(REG_GAIN, val);
      val = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
      write_reg(REG_DEFAULT_SEED, val);
      // Some phases run with the sender never pausing.
      src_idle = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(20, 80);
      repeat (burst) begin
        if ($urandom_range(0, 19) == 0)
          send_word(ACT_RESTART, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
        else
          send_word(ACT_GENERATE, $urandom);
      end
      sent += burst;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run.
  // --------------------------------------------------------------------------
  initial begin : run_tests
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_restart_seeds();
    test_register_extremes();
    test_zero_seed();
    test_raised_count();
    test_random_traffic();
    drain_and_pause();
    if (failures == 0) begin
      $display("pink_noise_voss_mccartney regression: pass");
    end else begin
      $display("pink_noise_voss_mccartney regression: fail");
    end
    $finish;
  end

endmodule
